### sv/slcan_pkg.sv
// Shared types and constants for the SLCAN transmit command parser.
package slcan_pkg;

    // Command letters
    localparam logic [7:0] CHAR_STD_DATA = 8'h74;  // 't'
    localparam logic [7:0] CHAR_EXT_DATA = 8'h54;  // 'T'
    localparam logic [7:0] CHAR_STD_RTR  = 8'h72;  // 'r'
    localparam logic [7:0] CHAR_EXT_RTR  = 8'h52;  // 'R'

    // Command kind: bit 0 extended, bit 1 remote
    localparam logic [1:0] KIND_STD_DATA = 2'd0;
    localparam logic [1:0] KIND_EXT_DATA = 2'd1;
    localparam logic [1:0] KIND_STD_RTR  = 2'd2;
    localparam logic [1:0] KIND_EXT_RTR  = 2'd3;
    localparam int         KIND_EXT_BIT  = 0;
    localparam int         KIND_RTR_BIT  = 1;

    localparam logic [31:0] STD_ID_MAX = 32'h0000_07FF;
    localparam logic [31:0] EXT_ID_MAX = 32'h1FFF_FFFF;
    localparam logic [4:0]  POS_MAX    = 5'd31;
    localparam logic [3:0]  STD_ID_LEN = 4'd3;
    localparam logic [3:0]  EXT_ID_LEN = 4'd8;
    localparam logic [3:0]  DLC_MAX    = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REPLY_OK_STD = 2'd0,
        REPLY_OK_EXT = 2'd1,
        REPLY_ERROR  = 2'd2
    } reply_t;

    // One classified character
    typedef struct packed {
        logic [3:0] nib;
        logic       hex_ok;
        logic [1:0] kind;
        logic       kind_ok;
        logic       last;
    } token_t;

    // Queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // One decoded command result
    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  data_length;
        logic        is_remote;
        logic        is_extended;
        logic [28:0] frame_id;
        reply_t      reply_code;
    } result_t;

endpackage

### sv/slcan_front.sv
// Front end: takes character beats and classifies them into tokens.
module slcan_front import slcan_pkg::*; (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    char_code,
    input  logic          end_of_command,
    input  queue_status_t q_status,
    output logic          push,
    output token_t        token
);

    // Take a beat whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    // Hex digit and command letter decode
    always_comb begin
        token      = '0;
        token.last = end_of_command;
        if (char_code >= 8'h30 && char_code <= 8'h39) begin
            token.hex_ok = 1'b1;
            token.nib    = char_code[3:0];
        end else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
                     (char_code >= 8'h61 && char_code <= 8'h66)) begin
            token.hex_ok = 1'b1;
            token.nib    = char_code[3:0] + 4'd9;
        end
        unique case (char_code)
            CHAR_STD_DATA: begin token.kind = KIND_STD_DATA; token.kind_ok = 1'b1; end
            CHAR_EXT_DATA: begin token.kind = KIND_EXT_DATA; token.kind_ok = 1'b1; end
            CHAR_STD_RTR:  begin token.kind = KIND_STD_RTR;  token.kind_ok = 1'b1; end
            CHAR_EXT_RTR:  begin token.kind = KIND_EXT_RTR;  token.kind_ok = 1'b1; end
            default:       begin token.kind = KIND_STD_DATA; token.kind_ok = 1'b0; end
        endcase
    end

endmodule

### sv/slcan_queue.sv
// Two-entry token queue between the front end and the back end.
module slcan_queue import slcan_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  token_t        push_token,
    input  logic          pop,
    output token_t        pop_token,
    output queue_status_t q_status
);

    token_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign q_status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_token      = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

### sv/slcan_back.sv
// Back end: accumulates ID, DLC and data digits and builds the result beat.
module slcan_back import slcan_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data,
    input  queue_status_t q_status,
    input  token_t        token,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output result_t       result
);

    logic        tx_en_reg;
    logic [4:0]  pos_reg, pos_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] id_reg, id_next;
    logic [3:0]  len_reg, len_next;
    logic [63:0] data_reg, data_next;
    logic        err_reg, err_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic [3:0]  id_len, id_len_end;
    logic [5:0]  data_end;
    logic [3:0]  digit_idx;
    logic [5:0]  nib_base;
    logic [5:0]  need;
    logic        ext_end, rtr_end, bad;

    assign cfg_ready = 1'b1;
    assign pop       = !q_status.empty && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign result    = out_reg;

    // Per-character update and end-of-command check
    always_comb begin
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        data_next      = data_reg;
        err_next       = err_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        id_len         = kind_reg[KIND_EXT_BIT] ? EXT_ID_LEN : STD_ID_LEN;
        data_end       = {2'b00, id_len} + 6'd2 + {1'b0, len_reg, 1'b0};
        digit_idx      = 4'(pos_reg - ({1'b0, id_len} + 5'd2));
        nib_base       = {4'd15 - digit_idx, 2'b00};
        ext_end        = 1'b0;
        rtr_end        = 1'b0;
        id_len_end     = STD_ID_LEN;
        need           = '0;
        bad            = 1'b0;

        if (pop) begin
            if (pos_reg == '0) begin
                if (token.kind_ok) begin
                    kind_next = token.kind;
                end else begin
                    kind_next = KIND_STD_DATA;
                    err_next  = 1'b1;
                end
            end else if (pos_reg <= {1'b0, id_len}) begin
                if (!token.hex_ok) err_next = 1'b1;
                else id_next = {id_reg[27:0], token.nib};
            end else if (pos_reg == {1'b0, id_len} + 5'd1) begin
                if (!token.hex_ok) begin
                    err_next = 1'b1;
                end else begin
                    len_next = token.nib;
                    if (token.nib > DLC_MAX) err_next = 1'b1;
                end
            end else if (!kind_reg[KIND_RTR_BIT] && len_reg <= DLC_MAX &&
                         {1'b0, pos_reg} < data_end) begin
                if (!token.hex_ok) err_next = 1'b1;
                else data_next[nib_base +: 4] = data_reg[nib_base +: 4] | token.nib;
            end

            if (pos_reg < POS_MAX) pos_next = pos_reg + 5'd1;

            if (token.last) begin
                ext_end    = kind_next[KIND_EXT_BIT];
                rtr_end    = kind_next[KIND_RTR_BIT];
                id_len_end = ext_end ? EXT_ID_LEN : STD_ID_LEN;
                need       = {2'b00, id_len_end} + 6'd2;
                bad        = err_next || ({1'b0, pos_next} < need);
                if (!bad) begin
                    if (len_next > DLC_MAX) begin
                        bad = 1'b1;
                    end else if (!rtr_end) begin
                        need = need + {1'b0, len_next, 1'b0};
                    end
                    if ({1'b0, pos_next} < need) bad = 1'b1;
                end
                if (ext_end ? (id_next > EXT_ID_MAX) : (id_next > STD_ID_MAX)) bad = 1'b1;
                if (!tx_en_reg) bad = 1'b1;

                // Load the result beat
                out_valid_next = 1'b1;
                out_next       = '0;
                if (bad) begin
                    out_next.reply_code = REPLY_ERROR;
                end else begin
                    out_next.reply_code  = ext_end ? REPLY_OK_EXT : REPLY_OK_STD;
                    out_next.frame_id    = id_next[28:0];
                    out_next.is_extended = ext_end;
                    out_next.is_remote   = rtr_end;
                    out_next.data_length = len_next;
                    out_next.payload     = rtr_end ? 64'd0 : data_next;
                end

                // Start a fresh command
                pos_next  = '0;
                kind_next = KIND_STD_DATA;
                id_next   = '0;
                len_next  = '0;
                data_next = '0;
                err_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_en_reg     <= 1'b0;
            pos_reg       <= '0;
            kind_reg      <= KIND_STD_DATA;
            id_reg        <= '0;
            len_reg       <= '0;
            data_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) tx_en_reg <= cfg_data;
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            data_reg      <= data_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

### sv/slcan_frame_command_parser_unit.sv
// SLCAN transmit command parser: front classifier, token queue, back accumulator.
// Throughput: one character beat per cycle while the token queue has room.
// m_tvalid rises once the last character has passed the token queue and the output register.
// The two-entry queue and the output register let each side stall on its own.
// Reset (aresetn low, synchronous): queue empty, command state cleared,
// no result pending, transmit disabled. No clearing pass.
module slcan_frame_command_parser_unit import slcan_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,     // tx_enabled
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,      // [7:0] char_code
    input  logic         s_tlast,      // end_of_command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata       // [1:0] reply_code, [30:2] frame_id, [31] is_extended,
                                       // [32] is_remote, [36:33] data_length,
                                       // [100:37] payload, [103:101] zero
);

    queue_status_t q_status;
    token_t        push_token, pop_token;
    logic          push, pop;
    result_t       result;

    slcan_front u_front (
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .char_code      (s_tdata),
        .end_of_command (s_tlast),
        .q_status       (q_status),
        .push           (push),
        .token          (push_token)
    );

    slcan_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .pop_token  (pop_token),
        .q_status   (q_status)
    );

    slcan_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .token     (pop_token),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    // Pack the result beat, last struct field lowest
    assign m_tdata = {3'b000, result};

endmodule

### sv/slcan_checker.sv
// Port-level checks for the SLCAN parser, bound to the top level.
module slcan_checker import slcan_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An error reply carries an all-zero frame
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == REPLY_ERROR |-> m_tdata[103:2] == '0)
        else $error("error reply with nonzero frame fields");

    // An ok reply matches the frame format and remote frames have no data
    a_ok_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != REPLY_ERROR |->
            (m_tdata[1:0] == REPLY_OK_STD || m_tdata[1:0] == REPLY_OK_EXT) &&
            m_tdata[31] == m_tdata[0] &&
            (!m_tdata[32] || m_tdata[100:37] == '0) && m_tdata[36:33] <= DLC_MAX)
        else $error("ok reply with inconsistent frame fields");

    // A standard frame ID stays within eleven bits
    a_std_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == REPLY_OK_STD |-> m_tdata[30:13] == '0)
        else $error("standard frame ID out of range");

endmodule

bind slcan_frame_command_parser_unit slcan_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb_slcan_frame_command_parser_unit.sv
// Self-checking testbench for the SLCAN transmit command parser: directed table plus random commands.
module tb_slcan_frame_command_parser_unit;
    import slcan_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_CHARS    = 100;
    localparam int MAX_GAP        = 14;

    // ASCII landmarks for hex digits
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_F = 8'h46;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_F = 8'h66;
    localparam logic [4:0] NIB_BAD       = 5'h10;

    typedef struct {
        bit      tx_on;
        string   text;
        bit      typed;
        result_t want;
    } cmd_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    // Parser state mirror
    logic [4:0]  cmd_pos;
    logic [1:0]  cmd_kind;
    logic [31:0] id_shift;
    logic [3:0]  dlc_held;
    logic [63:0] data_bits;
    bit          bad_seen;
    bit          tx_on_model;

    result_t     expected_frames[$];
    cmd_row_t    directed_rows[$];
    logic [7:0]  rand_chars[$];

    bit src_gaps_on;
    bit sink_stalls_on;
    int fail_count;
    int chars_sent;
    int commands_sent;
    int results_seen;
    int ok_std_seen;
    int ok_ext_seen;
    int error_seen_count;
    int cfg_writes;
    int idle_cycles;

    slcan_frame_command_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hex digit value, NIB_BAD for anything else
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= ASCII_ZERO && c <= ASCII_NINE) return {1'b0, 4'(c - ASCII_ZERO)};
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) return {1'b0, 4'(c - ASCII_UPPER_A + 10)};
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_F) return {1'b0, 4'(c - ASCII_LOWER_A + 10)};
        return NIB_BAD;
    endfunction

    // Hex digit character, random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return ASCII_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(v - 10);
    endfunction

    function automatic void clear_command();
        cmd_pos   = '0;
        cmd_kind  = KIND_STD_DATA;
        id_shift  = '0;
        dlc_held  = '0;
        data_bits = '0;
        bad_seen  = 1'b0;
    endfunction

    // Advance the parser by one character; returns 1 when a frame reply is due
    function automatic bit decode_char(input logic [7:0] c, input bit last, output result_t res);
        int         p;
        int         id_len;
        int         need;
        int         d;
        bit         ext;
        bit         rtr;
        bit         bad;
        logic [4:0] nib;
        p      = int'(cmd_pos);
        ext    = cmd_kind[KIND_EXT_BIT];
        rtr    = cmd_kind[KIND_RTR_BIT];
        id_len = ext ? int'(EXT_ID_LEN) : int'(STD_ID_LEN);
        nib    = hex_nibble(c);
        res    = '0;

        if (p == 0) begin
            case (c)
                CHAR_STD_DATA: cmd_kind = KIND_STD_DATA;
                CHAR_EXT_DATA: cmd_kind = KIND_EXT_DATA;
                CHAR_STD_RTR:  cmd_kind = KIND_STD_RTR;
                CHAR_EXT_RTR:  cmd_kind = KIND_EXT_RTR;
                default: begin
                    cmd_kind = KIND_STD_DATA;
                    bad_seen = 1'b1;
                end
            endcase
        end else if (p <= id_len) begin
            if (nib[4]) bad_seen = 1'b1;
            else id_shift = {id_shift[27:0], nib[3:0]};
        end else if (p == id_len + 1) begin
            if (nib[4]) begin
                bad_seen = 1'b1;
            end else begin
                dlc_held = nib[3:0];
                if (nib[3:0] > DLC_MAX) bad_seen = 1'b1;
            end
        end else if (!rtr && dlc_held <= DLC_MAX && p < id_len + 2 + 2 * int'(dlc_held)) begin
            d = p - (id_len + 2);
            if (nib[4]) bad_seen = 1'b1;
            else if (d < 16) data_bits |= 64'(nib[3:0]) << (60 - 4 * d);
        end

        if (cmd_pos < POS_MAX) cmd_pos++;
        if (!last) return 1'b0;

        // End of command: length, range and enable checks
        ext    = cmd_kind[KIND_EXT_BIT];
        rtr    = cmd_kind[KIND_RTR_BIT];
        id_len = ext ? int'(EXT_ID_LEN) : int'(STD_ID_LEN);
        need   = 2 + id_len;
        bad    = bad_seen;
        if (int'(cmd_pos) < need) bad = 1'b1;
        if (!bad) begin
            if (dlc_held > DLC_MAX) bad = 1'b1;
            else if (!rtr) need += 2 * int'(dlc_held);
            if (int'(cmd_pos) < need) bad = 1'b1;
        end
        if (ext ? (id_shift > EXT_ID_MAX) : (id_shift > STD_ID_MAX)) bad = 1'b1;
        if (!tx_on_model) bad = 1'b1;

        if (bad) begin
            res.reply_code = REPLY_ERROR;
        end else begin
            res.reply_code  = ext ? REPLY_OK_EXT : REPLY_OK_STD;
            res.frame_id    = id_shift[28:0];
            res.is_extended = ext;
            res.is_remote   = rtr;
            res.data_length = dlc_held;
            res.payload     = rtr ? 64'h0 : data_bits;
        end
        clear_command();
        return 1'b1;
    endfunction

    function automatic void add_row(input bit tx_on, input string text, input bit typed = 1'b0,
                                    input reply_t reply = REPLY_ERROR,
                                    input logic [28:0] id = '0, input logic [3:0] dlc = '0,
                                    input logic [63:0] data = '0);
        cmd_row_t row;
        row.tx_on = tx_on;
        row.text  = text;
        row.typed = typed;
        row.want  = '0;
        row.want.reply_code = reply;
        if (reply != REPLY_ERROR) begin
            row.want.frame_id    = id;
            row.want.is_extended = (reply == REPLY_OK_EXT);
            row.want.data_length = dlc;
            row.want.payload     = data;
        end
        directed_rows.push_back(row);
    endfunction

    // Send one command, one beat per character, tlast on the final one
    task automatic send_command(input logic [7:0] chars[$], input bit use_typed,
                                input result_t typed_want);
        int      gap;
        bit      got;
        bit      last;
        result_t res;
        for (int i = 0; i < chars.size(); i++) begin
            last = (i == chars.size() - 1);
            gap  = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= chars[i];
            s_tlast  <= last;
            do @(posedge aclk); while (!s_tready);
            got = decode_char(chars[i], last, res);
            if (got) expected_frames.push_back(use_typed ? typed_want : res);
            chars_sent++;
        end
        commands_sent++;
    endtask

    // Hold the input until every pending reply has been taken
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tx_enable(input bit value);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        tx_on_model = value;
        cfg_writes++;
    endtask

    // Mostly well-formed commands with random content, some corrupted, some pure noise
    task automatic build_random_command(output int useful);
        int          mode;
        int          n;
        int          id_len;
        int          dlc;
        int          pick;
        logic [1:0]  kind;
        logic [31:0] id;
        logic [31:0] id_lim;
        logic [7:0]  b;
        logic [4:0]  nib;
        rand_chars.delete();
        mode = $urandom_range(0, 99);
        if (mode < 8) begin
            n = $urandom_range(1, 40);
            repeat (n) rand_chars.push_back(8'($urandom_range(0, 255)));
            useful = (n < int'(POS_MAX)) ? n : int'(POS_MAX);
            return;
        end

        kind = 2'($urandom_range(0, 3));
        case (kind)
            KIND_STD_DATA: rand_chars.push_back(CHAR_STD_DATA);
            KIND_EXT_DATA: rand_chars.push_back(CHAR_EXT_DATA);
            KIND_STD_RTR:  rand_chars.push_back(CHAR_STD_RTR);
            default:       rand_chars.push_back(CHAR_EXT_RTR);
        endcase
        id_len = kind[KIND_EXT_BIT] ? int'(EXT_ID_LEN) : int'(STD_ID_LEN);
        id_lim = kind[KIND_EXT_BIT] ? EXT_ID_MAX : STD_ID_MAX;

        // Identifier: edges, just over range, any digits, or in range
        pick = $urandom_range(0, 9);
        case (pick)
            0:       id = id_lim;
            1:       id = '0;
            2:       id = id_lim + 1;
            3:       id = $urandom;
            default: id = $urandom & id_lim;
        endcase
        for (int i = id_len - 1; i >= 0; i--) rand_chars.push_back(hex_char(id[4 * i +: 4]));

        dlc = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        rand_chars.push_back(hex_char(4'(dlc)));
        if (!kind[KIND_RTR_BIT] && dlc <= DLC_MAX)
            repeat (2 * dlc) rand_chars.push_back(hex_char(4'($urandom_range(0, 15))));
        useful = rand_chars.size();

        // Corruption: a bad digit, a cut, or trailing junk
        mode = $urandom_range(0, 99);
        if (mode < 10) begin
            do begin
                b   = 8'($urandom_range(0, 255));
                nib = hex_nibble(b);
            end while (!nib[4]);
            rand_chars[$urandom_range(1, rand_chars.size() - 1)] = b;
        end else if (mode < 18) begin
            n = $urandom_range(1, rand_chars.size() - 1);
            while (rand_chars.size() > n) void'(rand_chars.pop_back());
            useful = n;
        end else if (mode < 30) begin
            repeat ($urandom_range(1, 24)) rand_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("result %0d: %s expected %h got %h", results_seen, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[100:0]);
            if (expected_frames.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result %0d: unexpected beat %h", results_seen, m_tdata);
            end else begin
                want = expected_frames.pop_front();
                check_field("reply_code", 64'(want.reply_code), 64'(got.reply_code));
                check_field("frame_id", 64'(want.frame_id), 64'(got.frame_id));
                check_field("is_extended", 64'(want.is_extended), 64'(got.is_extended));
                check_field("is_remote", 64'(want.is_remote), 64'(got.is_remote));
                check_field("data_length", 64'(want.data_length), 64'(got.data_length));
                check_field("payload", want.payload, got.payload);
                check_field("pad bits", 64'(0), 64'(m_tdata[103:101]));
            end
            case (got.reply_code)
                REPLY_OK_STD: ok_std_seen++;
                REPLY_OK_EXT: ok_ext_seen++;
                default:      error_seen_count++;
            endcase
            results_seen++;
        end
    end

    // Watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stall before each beat
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = sink_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int         useful;
        int         phase_chars;
        logic [7:0] chars[$];
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        tx_on_model    = 1'b0;
        clear_command();

        // Directed commands
        add_row(0, "t1230", 1, REPLY_ERROR);
        add_row(1, "t1230", 1, REPLY_OK_STD, 29'h123, 4'd0, 64'h0);
        add_row(1, "t0000", 1, REPLY_OK_STD, 29'h0, 4'd0, 64'h0);
        add_row(1, "t7FF8FFFFFFFFFFFFFFFF", 1, REPLY_OK_STD, 29'h7FF, 4'd8,
                64'hFFFF_FFFF_FFFF_FFFF);
        add_row(1, "T1FFFFFFF80123456789abcdef", 1, REPLY_OK_EXT, 29'h1FFF_FFFF, 4'd8,
                64'h0123_4567_89AB_CDEF);
        add_row(1, "T000000000", 1, REPLY_OK_EXT, 29'h0, 4'd0, 64'h0);
        add_row(1, "r1AB8");
        add_row(1, "R1f2E3d4C5");
        add_row(1, "t5Ea2bC9d");
        add_row(1, "t8000", 1, REPLY_ERROR);                // std id over range
        add_row(1, "T200000000", 1, REPLY_ERROR);           // ext id over range
        add_row(1, "t1239", 1, REPLY_ERROR);                // dlc over 8
        add_row(1, "t1G30", 1, REPLY_ERROR);                // bad id digit
        add_row(1, "t123g", 1, REPLY_ERROR);                // bad dlc digit
        add_row(1, "t1231a:", 1, REPLY_ERROR);              // bad data digit
        add_row(1, "t1232AB", 1, REPLY_ERROR);              // data cut short
        add_row(1, "t", 1, REPLY_ERROR);                    // letter only
        add_row(1, "T1234567", 1, REPLY_ERROR);             // id cut short
        add_row(1, "x1230", 1, REPLY_ERROR);                // unknown letter
        add_row(1, "t1232abcdXYZ");                         // trailing junk ignored
        add_row(1, "t1231a5..............................");   // position saturates
        add_row(1, "r7FF0ZZ");
        add_row(0, "T1FFFFFFF0", 1, REPLY_ERROR);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].tx_on != tx_on_model) write_tx_enable(directed_rows[r].tx_on);
            chars.delete();
            for (int i = 0; i < directed_rows[r].text.len(); i++)
                chars.push_back(directed_rows[r].text[i]);
            send_command(chars, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random phases: enable and idling pattern are set anew at each boundary
        for (int phase = 0; phase < PHASES; phase++) begin
            write_tx_enable((phase % 4 == 2) ? 1'b0 : 1'b1);
            case (phase % 3)
                0: begin
                    src_gaps_on    = 1'b1;
                    sink_stalls_on = 1'b1;
                end
                1: begin
                    src_gaps_on    = 1'b0;
                    sink_stalls_on = 1'b0;
                end
                default: begin
                    src_gaps_on    = 1'($urandom_range(0, 1));
                    sink_stalls_on = 1'($urandom_range(0, 1));
                end
            endcase
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS) begin
                build_random_command(useful);
                send_command(rand_chars, 1'b0, '0);
                phase_chars += useful;
            end
        end

        wait_for_idle();
        $display("ran %0d commands, %0d character beats, %0d enable writes, %0d directed",
                 commands_sent, chars_sent, cfg_writes, directed_rows.size());
        $display("took %0d replies: %0d standard ok, %0d extended ok, %0d error",
                 results_seen, ok_std_seen, ok_ext_seen, error_seen_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
sv/slcan_pkg.sv
sv/slcan_front.sv
sv/slcan_queue.sv
sv/slcan_back.sv
sv/slcan_frame_command_parser_unit.sv
sv/slcan_checker.sv
tb/tb_slcan_frame_command_parser_unit.sv
